[src/bee_pkg.sv]
// Shared types and constants for the bandwidth EMA estimator.
// No dependencies; imported by every module of the block except bee_addsub.
`default_nettype none
package bee_pkg;

  localparam int EST_W      = 48;   // width of the reported estimate
  localparam int ALPHA_BITS = 16;   // smoothing factor is Q0.16
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [ALPHA_BITS-1:0] ALPHA_DEFAULT = 16'd6554;  // about 0.1
  localparam logic [63:0]           INIT_RATE_INT = 64'd1000000000;

  // register select is paddr bit 3 (8-byte spacing)
  localparam logic REG_SMOOTHING = 1'b0;
  localparam logic REG_INIT      = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIFF,
    S_MUL,
    S_FIN,
    S_DONE
  } bee_state_t;

  typedef struct packed {
    logic [EST_W-1:0] estimate;
    logic             accepted;
    logic             primed_flag;
  } bee_result_t;

endpackage
`default_nettype wire

[src/bandwidth_ema_estimator_unit.sv]
// Top level of the bandwidth EMA estimator: stream ports, APB registers,
// output register. Depends on bee_pkg, bee_cfg_regs and bee_core.
`default_nettype none
// Bandwidth estimator. Each input word carries a byte count and an elapsed
// time count; the block turns them into a rate (bytes << FRAC_BITS) /
// elapsed, truncated, and folds it into an exponential moving average with
// weight smoothing_factor (Q0.16). The first good sample loads the average
// directly; until then every result reports initial_estimate. A word with a
// zero byte count or zero elapsed count is rejected: it still yields one
// result word, carrying the current estimate with accepted = 0. A rejected
// word skips the arithmetic and goes straight to its result; the first good
// word runs the divide and loads the average directly; later good words run
// the divide, the subtract, the multiply and the final add. All of it runs on
// one shared adder: one restoring-divide step per cycle for the rate, one
// subtract for sample minus estimate, 16 shift-add steps for the alpha
// multiply and one final add. in_tready is high only while the sequencer
// is idle; the result sits in an output register, so a new word can be
// taken while the previous result waits on out_tready. Registers (64-bit
// APB data, pready always high): 0x0 smoothing_factor, 0x8 initial_estimate;
// writing zero to either selects its default (about 0.1, and 1e9 in Q.16).
// Write registers only while the block is idle.
module bandwidth_ema_estimator_unit #(
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [COUNT_WIDTH-1:0] byte_count, [2*COUNT_WIDTH-1:COUNT_WIDTH] elapsed
  input  wire [((2*COUNT_WIDTH+7)/8)*8-1:0]   in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [47:0] estimate
  output logic [bee_pkg::EST_W-1:0]           out_tdata,
  // [0] accepted, [1] primed_flag
  output logic [1:0]                          out_tuser,
  // configuration
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [bee_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire [bee_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [bee_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import bee_pkg::*;

  localparam logic [63:0] INIT_WIDE = INIT_RATE_INT << FRAC_BITS;
  localparam logic [EST_W-1:0] INIT_DEFAULT = INIT_WIDE[EST_W-1:0];

  logic [ALPHA_BITS-1:0] alpha_eff;
  logic [EST_W-1:0]      init_eff;
  logic                  res_valid, res_ready;
  bee_result_t           res;

  logic                  out_valid_r, out_valid_nxt;
  bee_result_t           out_word_r, out_word_nxt;

  assign pready = 1'b1;

  bee_cfg_regs #(.INIT_DEFAULT(INIT_DEFAULT)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .alpha_eff (alpha_eff),
    .init_eff  (init_eff)
  );

  bee_core #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .byte_count (in_tdata[COUNT_WIDTH-1:0]),
    .elapsed    (in_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH]),
    .alpha_eff  (alpha_eff),
    .init_eff   (init_eff),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register: load when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r.estimate;
  assign out_tuser  = {out_word_r.primed_flag, out_word_r.accepted};

endmodule
`default_nettype wire

[src/bee_cfg_regs.sv]
// APB-style register file: smoothing factor and initial estimate.
// Depends on bee_pkg.
`default_nettype none
module bee_cfg_regs #(
  parameter logic [47:0] INIT_DEFAULT = 48'd65536000000000
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [bee_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire [bee_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bee_pkg::CFG_DATA_W-1:0] prdata,
  output logic [bee_pkg::ALPHA_BITS-1:0] alpha_eff,
  output logic [bee_pkg::EST_W-1:0]      init_eff
);
  import bee_pkg::*;

  logic [ALPHA_BITS-1:0] alpha_r, alpha_nxt;
  logic [EST_W-1:0]      init_r, init_nxt;
  logic                  wr_en;

  assign wr_en = psel & penable & pwrite;

  always_comb begin
    alpha_nxt = alpha_r;
    init_nxt  = init_r;
    if (wr_en) begin
      case (paddr[3])
        REG_SMOOTHING: alpha_nxt = pwdata[ALPHA_BITS-1:0];
        REG_INIT:      init_nxt  = pwdata[EST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_DEFAULT;
      init_r  <= INIT_DEFAULT;
    end else begin
      alpha_r <= alpha_nxt;
      init_r  <= init_nxt;
    end
  end

  always_comb begin
    case (paddr[3])
      REG_SMOOTHING: prdata = CFG_DATA_W'(alpha_r);
      REG_INIT:      prdata = CFG_DATA_W'(init_r);
      default:       prdata = '0;
    endcase
  end

  // zero written means "use the default"
  assign alpha_eff = (alpha_r == '0) ? ALPHA_DEFAULT : alpha_r;
  assign init_eff  = (init_r == '0) ? INIT_DEFAULT : init_r;

endmodule
`default_nettype wire

[src/bee_addsub.sv]
// Shared signed adder/subtractor used by every arithmetic step.
// No dependencies.
`default_nettype none
module bee_addsub #(
  parameter int W = 66
) (
  input  wire signed [W-1:0]  x,
  input  wire signed [W-1:0]  y,
  input  wire                 sub,
  output logic signed [W-1:0] sum
);
  logic signed [W-1:0] y_eff;

  assign y_eff = sub ? ~y : y;
  assign sum   = x + y_eff + W'(sub);

endmodule
`default_nettype wire

[src/bee_core.sv]
// Sequencer and datapath: restoring divide, then EMA blend, on one adder.
// Depends on bee_pkg and bee_addsub.
`default_nettype none
module bee_core #(
  parameter int FRAC_BITS   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [COUNT_WIDTH-1:0]       byte_count,
  input  wire [COUNT_WIDTH-1:0]       elapsed,
  input  wire [bee_pkg::ALPHA_BITS-1:0] alpha_eff,
  input  wire [bee_pkg::EST_W-1:0]    init_eff,
  output logic                        res_valid,
  input  wire                         res_ready,
  output bee_pkg::bee_result_t        res
);
  import bee_pkg::*;

  localparam int RATE_W = COUNT_WIDTH + FRAC_BITS;
  localparam int ACC_W  = RATE_W + 18;
  localparam int CNT_W  = $clog2(RATE_W);
  localparam int EXT_W  = (RATE_W > EST_W) ? RATE_W : EST_W;

  bee_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [RATE_W-1:0]      q_r, q_nxt;          // dividend in, quotient out
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [RATE_W-1:0]      est_r, est_nxt;
  logic                   primed_r, primed_nxt;
  logic                   ok_r, ok_nxt;
  logic [ALPHA_BITS-1:0]  alpha_r, alpha_nxt;
  logic signed [ACC_W-1:0] d_r, d_nxt;         // sample - estimate
  logic signed [ACC_W-1:0] acc_r, acc_nxt;     // alpha * d

  logic signed [ACC_W-1:0] alu_x, alu_y, alu_sum;
  logic                    alu_sub;
  logic [COUNT_WIDTH:0]    rem_sh;
  logic [EXT_W-1:0]        est_ext;

  bee_addsub #(.W(ACC_W)) u_alu (
    .x   (alu_x),
    .y   (alu_y),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign rem_sh = {rem_r, q_r[RATE_W-1]};

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    est_nxt    = est_r;
    primed_nxt = primed_r;
    ok_nxt     = ok_r;
    alpha_nxt  = alpha_r;
    d_nxt      = d_r;
    acc_nxt    = acc_r;
    alu_x      = '0;
    alu_y      = '0;
    alu_sub    = 1'b0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          q_nxt   = {byte_count, FRAC_BITS'(0)};
          rem_nxt = '0;
          dvs_nxt = elapsed;
          cnt_nxt = '0;
          ok_nxt  = (byte_count != '0) && (elapsed != '0);
          state_nxt = ((byte_count != '0) && (elapsed != '0)) ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        alu_x   = ACC_W'(rem_sh);
        alu_y   = ACC_W'(dvs_r);
        alu_sub = 1'b1;
        if (!alu_sum[ACC_W-1]) begin
          rem_nxt = alu_sum[COUNT_WIDTH-1:0];
          q_nxt   = {q_r[RATE_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[COUNT_WIDTH-1:0];
          q_nxt   = {q_r[RATE_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RATE_W - 1)) state_nxt = S_DIFF;
      end
      S_DIFF: begin
        alu_x   = ACC_W'(q_r);
        alu_y   = ACC_W'(est_r);
        alu_sub = 1'b1;
        if (!primed_r) begin
          est_nxt    = q_r;
          primed_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          d_nxt     = alu_sum;
          acc_nxt   = '0;
          alpha_nxt = alpha_eff;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // Horner, alpha MSB first
        alu_x     = acc_r <<< 1;
        alu_y     = alpha_r[ALPHA_BITS-1] ? d_r : '0;
        acc_nxt   = alu_sum;
        alpha_nxt = {alpha_r[ALPHA_BITS-2:0], 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ALPHA_BITS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        // est + floor(alpha*d / 2^16) == floor((a*s + (1-a)*e) / 2^16)
        alu_x     = ACC_W'(est_r);
        alu_y     = acc_r >>> ALPHA_BITS;
        est_nxt   = alu_sum[RATE_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      primed_r <= 1'b0;
      est_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      primed_r <= primed_nxt;
      est_r    <= est_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    ok_r    <= ok_nxt;
    alpha_r <= alpha_nxt;
    d_r     <= d_nxt;
    acc_r   <= acc_nxt;
  end

  assign est_ext          = EXT_W'(est_r);
  assign res.estimate     = primed_r ? est_ext[EST_W-1:0] : init_eff;
  assign res.accepted     = ok_r;
  assign res.primed_flag  = primed_r;

endmodule
`default_nettype wire
